### design/tts_pkg.sv
// Shared package for the token text phrase search block.
// Holds command, status and state codes plus default sizes; no dependencies.
package tts_pkg;

  localparam int unsigned TextDepthDef   = 4096;
  localparam int unsigned TokenBitsDef   = 32;
  localparam int unsigned PhraseDepthDef = 16;
  localparam int unsigned MaxHitsDef     = 63;

  typedef enum logic [2:0] {
    CMD_APPEND_TOKEN  = 3'd0,
    CMD_CLEAR_TEXT    = 3'd1,
    CMD_APPEND_PHRASE = 3'd2,
    CMD_WORD_SEARCH   = 3'd3,
    CMD_PHRASE_SEARCH = 3'd4,
    CMD_SNIPPET_SUM   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

endpackage

### design/tts_cell.sv
// One cell of the phrase matching chain: holds one phrase word and a
// partial-match flag that is handed to the next cell. Uses tts_pkg.
module tts_cell #(
  parameter int unsigned TOKEN_BITS = tts_pkg::TokenBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [TOKEN_BITS-1:0] load_word,
  input  logic                  clr,
  input  logic                  en,
  input  logic [TOKEN_BITS-1:0] token,
  input  logic                  prev_match,
  output logic                  match
);
  import tts_pkg::*;

  logic [TOKEN_BITS-1:0] word;

  // The phrase word is loaded once per phrase append.
  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
    end
  end

  // A match here means the phrase prefix up to this cell ends at the current token.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      match <= 1'b0;
    end else if (en) begin
      match <= prev_match && (token == word);
    end
  end

endmodule

### design/token_text_phrase_search.sv
// Top level of the token text phrase search block: text memory, scan
// sequencer, output register and the chain of tts_cell. Uses tts_pkg.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------
//  input   | in_valid  | in_stall  | command, token_value, start_pos, end_pos
//  output  | out_valid | out_stall | hit_position .. last (eight fields)
//
// Loads, clears and bad snippets give one item.
// A search scans the stored text at one token a cycle while the output
// is not stalled; a snippet sum scans the tokens from start_pos to end_pos.
// The single read port of the text memory sets the scan rate.
// Reset is synchronous; memory contents are left as they are.
// A stall on the output holds the whole scan pipeline in place.
module token_text_phrase_search #(
  parameter int unsigned TEXT_DEPTH   = tts_pkg::TextDepthDef,
  parameter int unsigned TOKEN_BITS   = tts_pkg::TokenBitsDef,
  parameter int unsigned PHRASE_DEPTH = tts_pkg::PhraseDepthDef,
  parameter int unsigned MAX_HITS     = tts_pkg::MaxHitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [31:0] token_value,
  input  logic [11:0] start_pos,
  input  logic [11:0] end_pos,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] hit_position,
  output logic [63:0] snippet_total,
  output logic [12:0] match_count,
  output logic        is_hit,
  output logic        truncated,
  output logic [1:0]  status,
  output logic [12:0] text_length,
  output logic        last
);
  import tts_pkg::*;

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam int CW = $clog2(TEXT_DEPTH + 1);
  localparam int PW = $clog2(PHRASE_DEPTH + 1);
  localparam int XW = (CW > 13) ? CW : 13;
  localparam int SW = ((AW > PW) ? AW : PW) + 1;

  // Registers.
  state_t                state, state_next;
  cmd_t                  op, op_next;
  logic [CW-1:0]         text_count, text_count_next;
  logic [PW-1:0]         phrase_count, phrase_count_next;
  logic [CW-1:0]         rd_ptr, rd_ptr_next;
  logic [CW-1:0]         limit, limit_next;
  logic [TOKEN_BITS-1:0] key, key_next;
  logic                  v1, v1_next, v2, v2_next;
  logic [AW-1:0]         pos1, pos1_next, pos2, pos2_next;
  logic                  word_match, word_match_next;
  logic [63:0]           sum, sum_next;
  logic [CW-1:0]         match_total, match_total_next;
  logic [5:0]            hits, hits_next;
  logic [TOKEN_BITS-1:0] rd_data;

  // Output register next values.
  logic        out_valid_next;
  logic [11:0] hit_position_next;
  logic [63:0] snippet_total_next;
  logic [12:0] match_count_next;
  logic        is_hit_next, truncated_next, last_next;
  logic [1:0]  status_next;
  logic [12:0] text_length_next;

  // Memory and cell controls.
  logic                  mem_we, rd_en, cell_clr, cell_en, phrase_load;
  logic [TOKEN_BITS-1:0] tok_in;
  logic [TOKEN_BITS+31:0] tok_wide;
  logic                  advance, in_take, phrase_hit, hit;
  logic [PHRASE_DEPTH:0] chain;
  logic [PHRASE_DEPTH-1:0] cell_load;
  logic [XW-1:0]         s_x, e_x, cnt_x;
  logic [SW-1:0]         start_w;

  logic [TOKEN_BITS-1:0] mem [TEXT_DEPTH];

  assign advance  = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !advance;
  assign in_take  = in_valid && !in_stall;

  assign tok_wide = {{TOKEN_BITS{1'b0}}, token_value};
  assign tok_in   = tok_wide[TOKEN_BITS-1:0];
  assign s_x      = XW'(start_pos);
  assign e_x      = XW'(end_pos);
  assign cnt_x    = XW'(text_count);

  // Text memory: one write port for appends, one registered read for the scan.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[text_count[AW-1:0]] <= tok_in;
    end
    if (rd_en) begin
      rd_data <= mem[rd_ptr[AW-1:0]];
    end
  end

  // Chain of matching cells; the first cell always sees a live prefix.
  assign chain[0] = 1'b1;
  assign cell_en  = (state == S_SCAN) && advance && v1;
  for (genvar i = 0; i < PHRASE_DEPTH; i++) begin : g_cell
    assign cell_load[i] = phrase_load && (phrase_count == PW'(i));
    tts_cell #(.TOKEN_BITS(TOKEN_BITS)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .load       (cell_load[i]),
      .load_word  (tok_in),
      .clr        (cell_clr),
      .en         (cell_en),
      .token      (rd_data),
      .prev_match (chain[i]),
      .match      (chain[i+1])
    );
  end

  // Pick the cell at the end of the current phrase.
  always_comb begin
    phrase_hit = 1'b0;
    for (int i = 0; i < PHRASE_DEPTH; i++) begin
      if (PW'(i + 1) == phrase_count) begin
        phrase_hit = chain[i+1];
      end
    end
  end

  assign hit     = (op == CMD_WORD_SEARCH) ? word_match
                                           : ((phrase_count != '0) && phrase_hit);
  assign start_w = SW'(pos2) + SW'(1) - SW'(phrase_count);

  // Command decode, scan sequencing and output loading.
  always_comb begin
    state_next         = state;
    op_next            = op;
    text_count_next    = text_count;
    phrase_count_next  = phrase_count;
    rd_ptr_next        = rd_ptr;
    limit_next         = limit;
    key_next           = key;
    v1_next            = v1;
    v2_next            = v2;
    pos1_next          = pos1;
    pos2_next          = pos2;
    word_match_next    = word_match;
    sum_next           = sum;
    match_total_next   = match_total;
    hits_next          = hits;
    mem_we             = 1'b0;
    rd_en              = 1'b0;
    cell_clr           = 1'b0;
    phrase_load        = 1'b0;
    out_valid_next     = advance ? 1'b0 : out_valid;
    hit_position_next  = hit_position;
    snippet_total_next = snippet_total;
    match_count_next   = match_count;
    is_hit_next        = is_hit;
    truncated_next     = truncated;
    status_next        = status;
    text_length_next   = text_length;
    last_next          = last;

    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          // Default single result; arms adjust it.
          out_valid_next     = 1'b1;
          hit_position_next  = '0;
          snippet_total_next = '0;
          match_count_next   = '0;
          is_hit_next        = 1'b0;
          truncated_next     = 1'b0;
          status_next        = ST_OK;
          last_next          = 1'b1;
          unique case (cmd_t'(command))
            CMD_APPEND_TOKEN: begin
              if (32'(text_count) >= TEXT_DEPTH) begin
                status_next = ST_FULL;
              end else begin
                mem_we          = 1'b1;
                text_count_next = text_count + CW'(1);
              end
            end
            CMD_CLEAR_TEXT: begin
              text_count_next = '0;
            end
            CMD_APPEND_PHRASE: begin
              if (32'(phrase_count) >= PHRASE_DEPTH) begin
                status_next = ST_FULL;
              end else begin
                phrase_load       = 1'b1;
                phrase_count_next = phrase_count + PW'(1);
              end
            end
            CMD_WORD_SEARCH, CMD_PHRASE_SEARCH: begin
              out_valid_next   = 1'b0;
              state_next       = S_SCAN;
              op_next          = cmd_t'(command);
              key_next         = tok_in;
              rd_ptr_next      = '0;
              limit_next       = text_count;
              match_total_next = '0;
              hits_next        = '0;
              v1_next          = 1'b0;
              v2_next          = 1'b0;
              cell_clr         = 1'b1;
            end
            CMD_SNIPPET_SUM: begin
              if ((e_x >= cnt_x) || (s_x > e_x)) begin
                status_next = ST_RANGE;
              end else begin
                out_valid_next = 1'b0;
                state_next     = S_SCAN;
                op_next        = CMD_SNIPPET_SUM;
                rd_ptr_next    = CW'(start_pos);
                limit_next     = CW'(end_pos) + CW'(1);
                sum_next       = '0;
                v1_next        = 1'b0;
                v2_next        = 1'b0;
              end
            end
            default: begin
            end
          endcase
          text_length_next = 13'(text_count_next);
        end
      end
      S_SCAN: begin
        if (advance) begin
          // Issue the next read.
          if (rd_ptr < limit) begin
            rd_en       = 1'b1;
            v1_next     = 1'b1;
            pos1_next   = rd_ptr[AW-1:0];
            rd_ptr_next = rd_ptr + CW'(1);
          end else begin
            v1_next = 1'b0;
          end
          // Compare stage.
          v2_next         = v1;
          pos2_next       = pos1;
          word_match_next = (rd_data == key);
          if (op == CMD_SNIPPET_SUM && v1) begin
            sum_next = sum + 64'(rd_data);
          end
          // Hit stage.
          if (op != CMD_SNIPPET_SUM && v2 && hit) begin
            match_total_next = match_total + CW'(1);
            if (32'(hits) < MAX_HITS) begin
              hits_next          = hits + 6'd1;
              out_valid_next     = 1'b1;
              hit_position_next  = (op == CMD_WORD_SEARCH) ? 12'(pos2) : 12'(start_w);
              snippet_total_next = '0;
              match_count_next   = '0;
              is_hit_next        = 1'b1;
              truncated_next     = 1'b0;
              status_next        = ST_OK;
              text_length_next   = 13'(text_count);
              last_next          = 1'b0;
            end
          end
          // Final result once the pipeline has drained.
          if (!(rd_ptr < limit) && !v1 && !v2) begin
            state_next         = S_IDLE;
            out_valid_next     = 1'b1;
            hit_position_next  = '0;
            is_hit_next        = 1'b0;
            status_next        = ST_OK;
            text_length_next   = 13'(text_count);
            last_next          = 1'b1;
            if (op == CMD_SNIPPET_SUM) begin
              snippet_total_next = sum;
              match_count_next   = '0;
              truncated_next     = 1'b0;
            end else begin
              snippet_total_next = '0;
              match_count_next   = 13'(match_total);
              truncated_next     = (32'(match_total) > MAX_HITS);
            end
            if (op == CMD_PHRASE_SEARCH) begin
              phrase_count_next = '0;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      text_count   <= '0;
      phrase_count <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      out_valid    <= 1'b0;
      hits         <= '0;
    end else begin
      state        <= state_next;
      text_count   <= text_count_next;
      phrase_count <= phrase_count_next;
      v1           <= v1_next;
      v2           <= v2_next;
      out_valid    <= out_valid_next;
      hits         <= hits_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op            <= op_next;
    rd_ptr        <= rd_ptr_next;
    limit         <= limit_next;
    key           <= key_next;
    pos1          <= pos1_next;
    pos2          <= pos2_next;
    word_match    <= word_match_next;
    sum           <= sum_next;
    match_total   <= match_total_next;
    hit_position  <= hit_position_next;
    snippet_total <= snippet_total_next;
    match_count   <= match_count_next;
    is_hit        <= is_hit_next;
    truncated     <= truncated_next;
    status        <= status_next;
    text_length   <= text_length_next;
    last          <= last_next;
  end

  // The scan pipeline is empty whenever the block waits for a command.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!v1 && !v2))
    else $error("scan pipeline busy while idle");

  // Hit results are never the final result of a command.
  a_hit_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_hit) |-> (!last && status == ST_OK))
    else $error("hit result marked as final");

  // The number of emitted hits stays within its limit.
  a_hit_limit: assert property (@(posedge clk) disable iff (rst)
    (32'(hits) <= MAX_HITS))
    else $error("too many hit results");

  // A held result keeps its hit_position and last while the output is stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hit_position) && $stable(last)))
    else $error("output changed under stall");

endmodule
